// ===== src/assert_macros.svh =====
// assertion macros shared by ped_div and the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off during reset
`define PED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define PED_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ped_pkg.sv =====
// constants, widths and sine table for the point to ellipse distance block
package ped_pkg;

	localparam int CF = 4;
	localparam int SF = 14;

	localparam int PXW = 12 + CF;
	localparam int DW = ((PXW > 16) ? PXW : 16) + 1;
	localparam int SINW = SF + 2;
	localparam int PW = DW + SINW;
	localparam int UW = PW + 1;
	localparam int NW = UW + 16;
	localparam int N2W = NW + 1 - (SF - 1);
	localparam int QB = 20;
	localparam int MW = QB + 1;
	localparam int MAG_CLIP = 1 << QB;
	localparam int SQW = 2 * MW + 1;
	localparam int SQ_RW = (SQW + 1) / 2;
	localparam int SQ_PW = 2 * SQ_RW;
	localparam int SQ_REMW = SQ_RW + 3;
	localparam int EW = SQ_RW + 2;
	localparam int DIST_W = 18;
	localparam int DIST_MAX = 131071;
	localparam int DIST_MIN = -131072;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_SIZE_A = 3'd2;
	localparam logic [2:0] REG_SIZE_B = 3'd3;
	localparam logic [2:0] REG_ANGLE = 3'd4;

	typedef logic [SF:0] sine_mag_t;
	typedef sine_mag_t sine_tab_t [91];
	typedef int unsigned raw_tab_t [91];

	// quarter-wave sine in units of 1e-7
	localparam raw_tab_t QS_T = '{
		0, 174524, 348995, 523360, 697565, 871557, 1045285, 1218693, 1391731,
		1564345, 1736482, 1908090, 2079117, 2249511, 2419219, 2588190, 2756374,
		2923717, 3090170, 3255682, 3420201, 3583679, 3746066, 3907311, 4067366,
		4226183, 4383711, 4539905, 4694716, 4848096, 5000000, 5150381, 5299193,
		5446390, 5591929, 5735764, 5877853, 6018150, 6156615, 6293204, 6427876,
		6560590, 6691306, 6819984, 6946584, 7071068, 7193398, 7313537, 7431448,
		7547096, 7660444, 7771460, 7880108, 7986355, 8090170, 8191520, 8290376,
		8386706, 8480481, 8571673, 8660254, 8746197, 8829476, 8910065, 8987940,
		9063078, 9135455, 9205049, 9271839, 9335804, 9396926, 9455186, 9510565,
		9563048, 9612617, 9659258, 9702957, 9743701, 9781476, 9816272, 9848078,
		9876883, 9902681, 9925462, 9945219, 9961947, 9975641, 9986295, 9993908,
		9998477, 10000000
	};

	function automatic sine_tab_t build_sine();
		sine_tab_t t;
		longint v;
		for (int i = 0; i < 91; i++) begin
			v = (longint'(QS_T[i]) * (longint'(1) << SF) + 64'sd5000000) / 64'sd10000000;
			t[i] = sine_mag_t'(v);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_Q = build_sine();

	// sine of k whole degrees, k below 360, in Q1.SF
	function automatic logic signed [SINW-1:0] sine_deg(input logic [8:0] k);
		logic [6:0] idx;
		logic neg;
		logic signed [SINW-1:0] m;
		if (k <= 9'd90) begin
			idx = 7'(k);
			neg = 1'b0;
		end else if (k <= 9'd180) begin
			idx = 7'(9'd180 - k);
			neg = 1'b0;
		end else if (k <= 9'd270) begin
			idx = 7'(k - 9'd180);
			neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - k);
			neg = 1'b1;
		end
		m = $signed({1'b0, SINE_Q[idx]});
		return neg ? -m : m;
	endfunction

endpackage

// ===== src/ped_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient clipped
`include "assert_macros.svh"

module ped_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [ped_pkg::N2W-1:0]   num,
	input  logic [15:0]               den,
	input  logic [ped_pkg::MW-1:0]    side_in,
	output logic                      out_valid,
	output logic [ped_pkg::MW-1:0]    quo,
	output logic [ped_pkg::MW-1:0]    side_out
);

	localparam int QB = ped_pkg::QB;

	logic [15:0]                rem_q  [QB+1];
	logic [QB-1:0]              quo_q  [QB+1];
	logic [QB-1:0]              low_q  [QB+1];
	logic                       ovf_q  [QB+1];
	logic [ped_pkg::MW-1:0]     side_q [QB+1];
	logic                       vld_q  [QB+1];

	// quotient would reach the clip value when the high part already covers den
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= num[QB+15:QB];
		low_q[0]  <= num[QB-1:0];
		ovf_q[0]  <= num[ped_pkg::N2W-1:QB] >= (ped_pkg::N2W-QB)'(den);
		quo_q[0]  <= '0;
		side_q[0] <= side_in;
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [16:0] trial;
		logic        take;

		always_comb begin
			trial = {rem_q[k-1], low_q[k-1][QB-1]};
			take = trial >= {1'b0, den};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k]  <= take ? 16'(trial - {1'b0, den}) : trial[15:0];
			quo_q[k]  <= {quo_q[k-1][QB-2:0], take};
			low_q[k]  <= low_q[k-1] << 1;
			ovf_q[k]  <= ovf_q[k-1];
			side_q[k] <= side_q[k-1];
		end
	end

	assign out_valid = vld_q[QB];
	assign quo = ovf_q[QB] ? ped_pkg::MW'(ped_pkg::MAG_CLIP) : {1'b0, quo_q[QB]};
	assign side_out = side_q[QB];

	`PED_ASSERT(a_quo_clipped, out_valid |-> (quo <= ped_pkg::MW'(ped_pkg::MAG_CLIP)), "quotient above clip")

endmodule

// ===== src/ped_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module ped_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [ped_pkg::SQW-1:0]     rad,
	output logic                        out_valid,
	output logic [ped_pkg::SQ_RW-1:0]   root
);

	localparam int RB = ped_pkg::SQ_RW;
	localparam int PB = ped_pkg::SQ_PW;
	localparam int REMW = ped_pkg::SQ_REMW;

	logic [REMW-1:0] rem_q  [RB+1];
	logic [RB-1:0]   root_q [RB+1];
	logic [PB-1:0]   rad_q  [RB+1];
	logic            vld_q  [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= '0;
		root_q[0] <= '0;
		rad_q[0]  <= PB'(rad);
	end

	for (genvar k = 1; k <= RB; k++) begin : g_stage
		logic [REMW-1:0] cur;
		logic [REMW-1:0] trial;
		logic            take;

		// bring down the next two radicand bits and try root*4+1
		always_comb begin
			cur = {rem_q[k-1][REMW-3:0], rad_q[k-1][PB-1 -: 2]};
			trial = REMW'({root_q[k-1], 2'b01});
			take = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k]  <= take ? cur - trial : cur;
			root_q[k] <= {root_q[k-1][RB-2:0], take};
			rad_q[k]  <= rad_q[k-1] << 2;
		end
	end

	assign out_valid = vld_q[RB];
	assign root = root_q[RB];

endmodule

// ===== src/point_to_ellipse_distance_top.sv =====
// top level: approximate signed distance from a pixel point to a rotated ellipse
//
// Takes one point per clock cycle with no gaps allowed or needed; busy is never
// raised. Each transaction passes from start through the stage registers, the
// 20-stage divider for the minor-axis stretch and the 22-stage square root
// pipeline to done. Results cannot be held off, so the receiver must take
// done whenever it is high. Configuration writes are taken every cycle
// (cfg_ready is tied high) and must only happen while no transaction is in
// flight.
`include "assert_macros.svh"

module point_to_ellipse_distance_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [11:0]                      point_x,
	input  logic [11:0]                      point_y,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [15:0]                      cfg_data,
	output logic                             done,
	output logic signed [ped_pkg::DIST_W-1:0] distance,
	output logic                             degenerate,
	output logic                             saturated
);

	localparam int DW = ped_pkg::DW;
	localparam int SINW = ped_pkg::SINW;
	localparam int PW = ped_pkg::PW;
	localparam int UW = ped_pkg::UW;
	localparam int NW = ped_pkg::NW;
	localparam int N2W = ped_pkg::N2W;
	localparam int MW = ped_pkg::MW;
	localparam int SF = ped_pkg::SF;
	localparam int EW = ped_pkg::EW;
	localparam int RW = ped_pkg::SQ_RW;
	localparam logic signed [EW-1:0] DMAX_E = EW'(ped_pkg::DIST_MAX);
	localparam logic signed [EW-1:0] DMIN_E = EW'(ped_pkg::DIST_MIN);

	logic [15:0] center_x_q, center_y_q, size_a_q, size_b_q;
	logic [8:0]  angle_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			size_a_q   <= 16'd16;
			size_b_q   <= 16'd16;
			angle_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ped_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				ped_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				ped_pkg::REG_SIZE_A:   size_a_q <= cfg_data;
				ped_pkg::REG_SIZE_B:   size_b_q <= cfg_data;
				ped_pkg::REG_ANGLE:    angle_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// static geometry from the registers
	logic [15:0] mx, mn;
	logic [8:0]  ang, cang;
	logic [9:0]  ang90;
	logic signed [SINW-1:0] sin_v, cos_v;

	always_comb begin
		mx = (size_a_q > size_b_q) ? size_a_q : size_b_q;
		mn = (size_a_q > size_b_q) ? size_b_q : size_a_q;
		ang = (angle_q >= 9'd360) ? 9'(angle_q - 9'd360) : angle_q;
		ang90 = {1'b0, ang} + 10'd90;
		cang = (ang90 >= 10'd360) ? 9'(ang90 - 10'd360) : ang90[8:0];
		sin_v = ped_pkg::sine_deg(ang);
		cos_v = ped_pkg::sine_deg(cang);
	end

	// stage 1: offsets from center
	logic signed [DW-1:0] dx_c, dy_c;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [SINW-1:0] sin_s1, cos_s1;
	logic v_s1;

	always_comb begin
		dx_c = ($signed({{(DW-12){1'b0}}, point_x}) <<< ped_pkg::CF)
			- $signed({{(DW-16){1'b0}}, center_x_q});
		dy_c = ($signed({{(DW-12){1'b0}}, point_y}) <<< ped_pkg::CF)
			- $signed({{(DW-16){1'b0}}, center_y_q});
	end

	// stage 2: rotation products
	logic signed [PW-1:0] pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic v_s2;

	// stage 3: rotated magnitudes
	logic signed [UW-1:0] u_c, w_c;
	logic [UW-1:0] umag_c, wmag_c, um_full;
	logic [MW-1:0] um_s3;
	logic [UW-1:0] wm_s3;
	logic v_s3;

	always_comb begin
		u_c = UW'(pcx_s2) + UW'(psy_s2);
		w_c = UW'(pcy_s2) - UW'(psx_s2);
		umag_c = u_c[UW-1] ? UW'(-u_c) : UW'(u_c);
		wmag_c = w_c[UW-1] ? UW'(-w_c) : UW'(w_c);
		um_full = (umag_c + UW'(1 << (SF - 2))) >> (SF - 1);
	end

	// stage 4: stretch numerator, stage 5: rounding and scale for the divider
	logic [NW-1:0] n_s4;
	logic [MW-1:0] um_s4, um_s5;
	logic v_s4, v_s5;
	logic [NW:0] nr_c;
	logic [N2W-1:0] num_s5;

	assign nr_c = {1'b0, n_s4} + ((NW+1)'(mn) << (SF - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dx_c;
		dy_s1  <= dy_c;
		sin_s1 <= sin_v;
		cos_s1 <= cos_v;
		pcx_s2 <= cos_s1 * dx_s1;
		psy_s2 <= sin_s1 * dy_s1;
		psx_s2 <= sin_s1 * dx_s1;
		pcy_s2 <= cos_s1 * dy_s1;
		um_s3  <= (um_full > UW'(ped_pkg::MAG_CLIP)) ? MW'(ped_pkg::MAG_CLIP) : MW'(um_full);
		wm_s3  <= wmag_c;
		n_s4   <= NW'(wm_s3 * mx);
		um_s4  <= um_s3;
		num_s5 <= nr_c[NW:SF-1];
		um_s5  <= um_s4;
	end

	// minor-axis stretch divided out by mn
	logic dv_valid;
	logic [MW-1:0] vm, um_d;

	ped_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.num      (num_s5),
		.den      (mn),
		.side_in  (um_s5),
		.out_valid(dv_valid),
		.quo      (vm),
		.side_out (um_d)
	);

	// stage 6: squares, stage 7: radius squared
	logic [2*MW-1:0] usq_s6, vsq_s6;
	logic [ped_pkg::SQW-1:0] rad_s7;
	logic v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s6 <= dv_valid;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		usq_s6 <= um_d * um_d;
		vsq_s6 <= vm * vm;
		rad_s7 <= ped_pkg::SQW'(usq_s6) + ped_pkg::SQW'(vsq_s6);
	end

	logic sq_valid;
	logic [RW-1:0] root;

	ped_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.rad      (rad_s7),
		.out_valid(sq_valid),
		.root     (root)
	);

	// final: half of major minus radius, rounded, then clipped; zero when the minor size is zero
	logic signed [EW-1:0] d2, xr, xh;
	logic over, under, degen;

	always_comb begin
		d2 = $signed({{(EW-16){1'b0}}, mx}) - $signed({{(EW-RW){1'b0}}, root});
		xr = d2 + $signed(EW'(1));
		xh = xr >>> 1;
		over = xh > DMAX_E;
		under = xh < DMIN_E;
		degen = mn == 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		degenerate <= degen;
		saturated <= !degen && (over || under);
		if (degen) begin
			distance <= '0;
		end else if (over) begin
			distance <= ped_pkg::DIST_W'(ped_pkg::DIST_MAX);
		end else if (under) begin
			distance <= ped_pkg::DIST_W'(ped_pkg::DIST_MIN);
		end else begin
			distance <= xh[ped_pkg::DIST_W-1:0];
		end
	end

	`PED_ASSERT(a_degen_zero, (done && degenerate) |-> (distance == '0 && !saturated), "degenerate result not zero")
	`PED_ASSERT(a_sat_extreme, (done && saturated) |-> (distance == ped_pkg::DIST_W'(ped_pkg::DIST_MAX) || distance == ped_pkg::DIST_W'(ped_pkg::DIST_MIN)), "saturated result not at a limit")

endmodule
